>>> sv/pov_clock_glyph_sequencer_core_macros.svh
// Assertion macros for the POV clock glyph sequencer core.
`ifndef POV_CLOCK_GLYPH_SEQUENCER_CORE_MACROS_SVH
`define POV_CLOCK_GLYPH_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PCGS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcgs assertion failed");
`define PCGS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcgs assertion failed");
`else
`define PCGS_ASSERT_SAME(label, ante, cons)
`define PCGS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> sv/pcgs_pkg.sv
// Package with types, constants and glyph tables of the POV clock glyph sequencer.
`timescale 1ns / 1ps
package pcgs_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int NUM_DIGITS = 6;
	localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);

	localparam logic [DIGIT_IDX_W-1:0] COLON_AFTER_HOURS = DIGIT_IDX_W'(1);
	localparam logic [DIGIT_IDX_W-1:0] COLON_AFTER_MINUTES = DIGIT_IDX_W'(3);
	localparam logic [DIGIT_IDX_W-1:0] LAST_DIGIT = DIGIT_IDX_W'(NUM_DIGITS - 1);

	localparam logic [2:0] WIDTH_DIGIT = 3'd5;
	localparam logic [2:0] WIDTH_NARROW = 3'd3;
	localparam logic [7:0] COL_BLANK = 8'hFF;
	localparam logic [7:0] COL_DOTS = 8'hDB;

	typedef struct packed {
		logic       sensor_level;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} pcgs_scan_t;

	typedef struct packed {
		logic [7:0] column0;
		logic [7:0] column1;
		logic [7:0] column2;
		logic [7:0] column3;
		logic [7:0] column4;
		logic [2:0] column_count;
		logic       last_segment;
	} pcgs_seg_t;

	typedef struct packed {
		logic [NUM_DIGITS-1:0][3:0] digit;
		logic [NUM_DIGITS-1:0]      lead;
	} pcgs_cmd_t;

	typedef struct packed {
		logic      valid;
		pcgs_cmd_t cmd;
	} pcgs_push_t;

	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] units;
	} pcgs_split_t;

	typedef logic [0:4][7:0] pcgs_glyph_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LEAD,
		BK_DIGIT,
		BK_TRAIL,
		BK_COLON
	} pcgs_bk_state_t;

	function automatic pcgs_split_t split_tens(input logic [5:0] v);
		pcgs_split_t r;
		logic [5:0]  tens_times_ten;
		r.tens = 4'(v >= 6'd10) + 4'(v >= 6'd20) + 4'(v >= 6'd30)
			+ 4'(v >= 6'd40) + 4'(v >= 6'd50) + 4'(v >= 6'd60);
		tens_times_ten = {r.tens[2:0], 3'b000} + {2'b00, r.tens[2:0], 1'b0};
		r.units = 4'(v - tens_times_ten);
		return r;
	endfunction

	function automatic pcgs_glyph_t digit_glyph(input logic [3:0] d);
		pcgs_glyph_t g;
		case (d)
			4'd0: g = '{8'h83, 8'h7D, 8'h7D, 8'h7D, 8'h83};
			4'd1: g = '{8'hFF, 8'hBD, 8'h01, 8'hFD, 8'hFF};
			4'd2: g = '{8'hBD, 8'h79, 8'h75, 8'h6D, 8'h9D};
			4'd3: g = '{8'hBB, 8'h6D, 8'h6D, 8'h6D, 8'h93};
			4'd4: g = '{8'hE7, 8'hD7, 8'hB7, 8'h61, 8'hF7};
			4'd5: g = '{8'h1B, 8'h6D, 8'h6D, 8'h6D, 8'h73};
			4'd6: g = '{8'h83, 8'h6D, 8'h6D, 8'h6D, 8'h73};
			4'd7: g = '{8'h7F, 8'h7F, 8'h61, 8'h5F, 8'h3F};
			4'd8: g = '{8'h83, 8'h6D, 8'h6D, 8'h6D, 8'h83};
			4'd9: g = '{8'h9F, 8'h6D, 8'h6D, 8'h6D, 8'h83};
			default: g = '{COL_BLANK, COL_BLANK, COL_BLANK, COL_BLANK, COL_BLANK};
		endcase
		return g;
	endfunction

endpackage

>>> sv/pov_clock_glyph_sequencer_core.sv
// Top level of the POV clock glyph sequencer core.
`timescale 1ns / 1ps
`include "pov_clock_glyph_sequencer_core_macros.svh"
// Scans are taken one per cycle while the command queue (QUEUE_DEPTH entries)
// has room; a scan whose sensor level falls from 1 to 0 queues one display
// command. The sequencer turns each command into 14 to 17 glyph segments
// HH:MM:SS, one segment per cycle from an output register while seg_stall is
// low, after an idle state that starts each command. Scans with no falling
// edge queue nothing and are taken while the back end works.
module pov_clock_glyph_sequencer_core #(
	parameter int QUEUE_DEPTH = pcgs_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 scan_valid,
	output logic                 scan_stall,
	input  pcgs_pkg::pcgs_scan_t scan,
	output logic                 seg_valid,
	input  logic                 seg_stall,
	output pcgs_pkg::pcgs_seg_t  seg
);

	pcgs_pkg::pcgs_push_t push;
	pcgs_pkg::pcgs_cmd_t  head;
	logic                 q_full;
	logic                 head_valid;
	logic                 pop;

	pcgs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_valid (scan_valid),
		.scan_stall (scan_stall),
		.scan       (scan),
		.q_full     (q_full),
		.push       (push)
	);

	pcgs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	pcgs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.seg_valid  (seg_valid),
		.seg_stall  (seg_stall),
		.seg        (seg)
	);

	`PCGS_ASSERT_SAME(a_last_is_space, seg_valid && seg.last_segment, seg.column_count == pcgs_pkg::WIDTH_NARROW && seg.column0 == pcgs_pkg::COL_BLANK)
	`PCGS_ASSERT_SAME(a_width_legal, seg_valid, seg.column_count == pcgs_pkg::WIDTH_NARROW || seg.column_count == pcgs_pkg::WIDTH_DIGIT)
	`PCGS_ASSERT_SAME(a_narrow_tail_zero, seg_valid && seg.column_count == pcgs_pkg::WIDTH_NARROW, seg.column3 == 8'h00 && seg.column4 == 8'h00)
	`PCGS_ASSERT_NEXT(a_pop_ends_segment, pop, seg_valid && seg.last_segment)

endmodule

>>> sv/pcgs_front.sv
// Front end: sensor edge detection and time split into digits with leading-space marks.
`timescale 1ns / 1ps
module pcgs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 scan_valid,
	output logic                 scan_stall,
	input  pcgs_pkg::pcgs_scan_t scan,
	input  logic                 q_full,
	output pcgs_pkg::pcgs_push_t push
);

	logic                  prev_level_q;
	logic                  accept;
	pcgs_pkg::pcgs_split_t h_split;
	pcgs_pkg::pcgs_split_t m_split;
	pcgs_pkg::pcgs_split_t s_split;

	assign scan_stall = q_full;
	assign accept = scan_valid && !scan_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b1;
		end else if (accept) begin
			prev_level_q <= scan.sensor_level;
		end
	end

	assign h_split = pcgs_pkg::split_tens({1'b0, scan.hours});
	assign m_split = pcgs_pkg::split_tens(scan.minutes);
	assign s_split = pcgs_pkg::split_tens(scan.seconds);

	always_comb begin
		push.valid = accept && prev_level_q && !scan.sensor_level;
		push.cmd.digit[0] = h_split.tens;
		push.cmd.digit[1] = h_split.units;
		push.cmd.digit[2] = m_split.tens;
		push.cmd.digit[3] = m_split.units;
		push.cmd.digit[4] = s_split.tens;
		push.cmd.digit[5] = s_split.units;
		push.cmd.lead[0] = (h_split.tens == 4'd8);
		push.cmd.lead[1] = (h_split.units == 4'd6) || (h_split.units == 4'd8);
		push.cmd.lead[2] = (m_split.tens == 4'd0);
		push.cmd.lead[3] = 1'b0;
		push.cmd.lead[4] = (s_split.tens == 4'd0);
		push.cmd.lead[5] = 1'b0;
	end

endmodule

>>> sv/pcgs_queue.sv
// Command queue between the front end and the segment sequencer.
`timescale 1ns / 1ps
module pcgs_queue #(
	parameter int DEPTH = pcgs_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pcgs_pkg::pcgs_push_t push,
	output logic                 full,
	output logic                 head_valid,
	output pcgs_pkg::pcgs_cmd_t  head,
	input  logic                 pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	pcgs_pkg::pcgs_cmd_t entry_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign full = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head = entry_q[rd_ptr_q];
	assign do_push = push.valid && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/pcgs_back.sv
// Back end: walks one command through its glyph segments into the output register.
`timescale 1ns / 1ps
module pcgs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  pcgs_pkg::pcgs_cmd_t head,
	output logic                pop,
	output logic                seg_valid,
	input  logic                seg_stall,
	output pcgs_pkg::pcgs_seg_t seg
);

	localparam int IW = pcgs_pkg::DIGIT_IDX_W;

	pcgs_pkg::pcgs_bk_state_t state_q;
	pcgs_pkg::pcgs_bk_state_t state_d;
	logic [IW-1:0]            idx_q;
	logic [IW-1:0]            idx_d;
	logic [IW-1:0]            idx_next;
	logic                     out_free;
	logic                     emit;
	logic                     on_last;
	pcgs_pkg::pcgs_glyph_t    glyph;
	pcgs_pkg::pcgs_seg_t      seg_d;
	pcgs_pkg::pcgs_seg_t      seg_q;
	logic                     seg_valid_q;

	assign out_free = !seg_valid_q || !seg_stall;
	assign emit = (state_q != pcgs_pkg::BK_IDLE) && out_free;
	assign on_last = (state_q == pcgs_pkg::BK_TRAIL) && (idx_q == pcgs_pkg::LAST_DIGIT);
	assign pop = emit && on_last;
	assign idx_next = idx_q + 1'b1;
	assign glyph = pcgs_pkg::digit_glyph(head.digit[idx_q]);

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		unique case (state_q)
			pcgs_pkg::BK_IDLE: begin
				if (head_valid) begin
					idx_d = '0;
					state_d = head.lead[0] ? pcgs_pkg::BK_LEAD : pcgs_pkg::BK_DIGIT;
				end
			end
			pcgs_pkg::BK_LEAD: begin
				if (out_free) begin
					state_d = pcgs_pkg::BK_DIGIT;
				end
			end
			pcgs_pkg::BK_DIGIT: begin
				if (out_free) begin
					state_d = pcgs_pkg::BK_TRAIL;
				end
			end
			pcgs_pkg::BK_TRAIL: begin
				if (out_free) begin
					if (idx_q == pcgs_pkg::LAST_DIGIT) begin
						state_d = pcgs_pkg::BK_IDLE;
					end else begin
						idx_d = idx_next;
						if (idx_q == pcgs_pkg::COLON_AFTER_HOURS ||
							idx_q == pcgs_pkg::COLON_AFTER_MINUTES) begin
							state_d = pcgs_pkg::BK_COLON;
						end else begin
							state_d = head.lead[idx_next] ? pcgs_pkg::BK_LEAD
								: pcgs_pkg::BK_DIGIT;
						end
					end
				end
			end
			pcgs_pkg::BK_COLON: begin
				if (out_free) begin
					state_d = head.lead[idx_q] ? pcgs_pkg::BK_LEAD : pcgs_pkg::BK_DIGIT;
				end
			end
			default: begin
				state_d = pcgs_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		seg_d.column0 = pcgs_pkg::COL_BLANK;
		seg_d.column1 = pcgs_pkg::COL_BLANK;
		seg_d.column2 = pcgs_pkg::COL_BLANK;
		seg_d.column3 = 8'h00;
		seg_d.column4 = 8'h00;
		seg_d.column_count = pcgs_pkg::WIDTH_NARROW;
		seg_d.last_segment = on_last;
		unique case (state_q)
			pcgs_pkg::BK_DIGIT: begin
				seg_d.column0 = glyph[0];
				seg_d.column1 = glyph[1];
				seg_d.column2 = glyph[2];
				seg_d.column3 = glyph[3];
				seg_d.column4 = glyph[4];
				seg_d.column_count = pcgs_pkg::WIDTH_DIGIT;
			end
			pcgs_pkg::BK_COLON: begin
				seg_d.column1 = pcgs_pkg::COL_DOTS;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcgs_pkg::BK_IDLE;
			idx_q <= '0;
			seg_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (emit) begin
				seg_valid_q <= 1'b1;
			end else if (!seg_stall) begin
				seg_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			seg_q <= seg_d;
		end
	end

	assign seg_valid = seg_valid_q;
	assign seg = seg_q;

endmodule

>>> tb/sv/tb_pov_clock_glyph_sequencer_core.sv
// Testbench for the POV clock glyph sequencer core: scans in, predicted glyph segments checked out.
`timescale 1ns / 1ps
module tb_pov_clock_glyph_sequencer_core;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [39:0] DIGIT_COLUMNS [10] = '{
		40'h837D7D7D83, 40'hFFBD01FDFF, 40'hBD79756D9D, 40'hBB6D6D6D93,
		40'hE7D7B761F7, 40'h1B6D6D6D73, 40'h836D6D6D73, 40'h7F7F615F3F,
		40'h836D6D6D83, 40'h9F6D6D6D83
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 scan_valid = 1'b0;
	logic                 scan_stall;
	pcgs_pkg::pcgs_scan_t scan = '0;
	logic                 seg_valid;
	logic                 seg_stall = 1'b0;
	pcgs_pkg::pcgs_seg_t  seg;

	pcgs_pkg::pcgs_seg_t  glyph_segments[$];
	logic                 last_level = 1'b1;
	bit                   idling_on = 1'b1;
	bit                   hold_output = 1'b0;
	int                   hold_left = 0;
	int                   quiet_cycles = 0;
	int                   mismatch_count = 0;
	int                   scans_sent = 0;
	int                   falling_edges = 0;
	int                   segs_checked = 0;

	pov_clock_glyph_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_valid(scan_valid),
		.scan_stall(scan_stall),
		.scan      (scan),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic pcgs_pkg::pcgs_seg_t narrow_seg(input logic [7:0] middle);
		pcgs_pkg::pcgs_seg_t s;
		s = '0;
		s.column0 = pcgs_pkg::COL_BLANK;
		s.column1 = middle;
		s.column2 = pcgs_pkg::COL_BLANK;
		s.column_count = pcgs_pkg::WIDTH_NARROW;
		return s;
	endfunction

	function automatic pcgs_pkg::pcgs_seg_t digit_seg(input int d);
		pcgs_pkg::pcgs_seg_t s;
		logic [39:0]         cols;
		cols = DIGIT_COLUMNS[d];
		s = '0;
		{s.column0, s.column1, s.column2, s.column3, s.column4} = cols;
		s.column_count = pcgs_pkg::WIDTH_DIGIT;
		return s;
	endfunction

	function automatic void add_digit(ref pcgs_pkg::pcgs_seg_t run[$], input int d,
		input bit lead);
		if (lead)
			run.push_back(narrow_seg(pcgs_pkg::COL_BLANK));
		run.push_back(digit_seg(d));
		run.push_back(narrow_seg(pcgs_pkg::COL_BLANK));
	endfunction

	function automatic void predict_scan(input pcgs_pkg::pcgs_scan_t s);
		pcgs_pkg::pcgs_seg_t run[$];
		int                  h_tens, h_units, m_tens, m_units, s_tens, s_units;
		if (s.sensor_level == last_level)
			return;
		last_level = s.sensor_level;
		if (s.sensor_level)
			return;
		h_tens = int'(s.hours) / 10;
		h_units = int'(s.hours) % 10;
		m_tens = int'(s.minutes) / 10;
		m_units = int'(s.minutes) % 10;
		s_tens = int'(s.seconds) / 10;
		s_units = int'(s.seconds) % 10;
		add_digit(run, h_tens, h_tens == 8);
		add_digit(run, h_units, h_units == 6 || h_units == 8);
		run.push_back(narrow_seg(pcgs_pkg::COL_DOTS));
		add_digit(run, m_tens, m_tens == 0);
		add_digit(run, m_units, 1'b0);
		run.push_back(narrow_seg(pcgs_pkg::COL_DOTS));
		add_digit(run, s_tens, s_tens == 0);
		add_digit(run, s_units, 1'b0);
		run[run.size() - 1].last_segment = 1'b1;
		foreach (run[i])
			glyph_segments.push_back(run[i]);
		falling_edges++;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(negedge clk) begin
		pcgs_pkg::pcgs_seg_t want;
		if (arst_n) begin
			if ((scan_valid && !scan_stall) || (seg_valid && !seg_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_pov_clock_glyph_sequencer_core NOT OK");
				$finish;
			end
			if (seg_valid && !seg_stall) begin
				if (glyph_segments.size() == 0) begin
					$error("unexpected segment transaction: 0x%0h", seg);
					mismatch_count++;
				end else begin
					want = glyph_segments.pop_front();
					check_field("column0", want.column0, seg.column0);
					check_field("column1", want.column1, seg.column1);
					check_field("column2", want.column2, seg.column2);
					check_field("column3", want.column3, seg.column3);
					check_field("column4", want.column4, seg.column4);
					check_field("column_count", want.column_count, seg.column_count);
					check_field("last_segment", want.last_segment, seg.last_segment);
					segs_checked++;
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				seg_stall <= 1'b1;
				hold_left--;
			end else if (hold_output) begin
				hold_output = 1'b0;
				hold_left = HOLD_CYCLES;
				seg_stall <= 1'b1;
			end else begin
				seg_stall <= idling_on && ($urandom_range(0, 99) < 30);
			end
		end
	end

	task automatic send_scan(input logic level, input int hr, input int mi, input int se);
		pcgs_pkg::pcgs_scan_t s;
		s.sensor_level = level;
		s.hours = hr[4:0];
		s.minutes = mi[5:0];
		s.seconds = se[5:0];
		while (idling_on && $urandom_range(0, 99) < 30) begin
			scan_valid <= 1'b0;
			@(posedge clk);
		end
		scan <= s;
		scan_valid <= 1'b1;
		do
			@(negedge clk);
		while (scan_stall);
		predict_scan(s);
		scans_sent++;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		scan_valid <= 1'b0;
		while (glyph_segments.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_digit_glyphs();
		send_scan(1'b0, 0, 0, 0);
		send_scan(1'b1, 31, 63, 63);
		send_scan(1'b0, 31, 63, 63);
		send_scan(1'b1, 0, 0, 0);
		send_scan(1'b0, 8, 10, 10);
		send_scan(1'b1, 8, 10, 10);
		send_scan(1'b0, 16, 27, 34);
		send_scan(1'b1, 16, 27, 34);
		send_scan(1'b0, 23, 59, 59);
		send_scan(1'b1, 0, 0, 0);
		send_scan(1'b0, 19, 48, 7);
		send_scan(1'b1, 0, 0, 0);
		send_scan(1'b0, 12, 36, 45);
		send_scan(1'b1, 0, 0, 0);
		send_scan(1'b0, 28, 60, 61);
		wait_drained();
	endtask

	task automatic test_level_without_edge();
		send_scan(1'b0, 5, 5, 5);
		send_scan(1'b0, 31, 0, 63);
		send_scan(1'b1, 21, 42, 13);
		send_scan(1'b1, 0, 63, 0);
		send_scan(1'b0, 30, 0, 9);
		send_scan(1'b0, 1, 1, 1);
		wait_drained();
	endtask

	task automatic test_output_hold();
		hold_output = 1'b1;
		repeat (8) begin
			send_scan(1'b1, $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
			send_scan(1'b0, $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
		end
		wait_drained();
	endtask

	task automatic random_time(output int hr, output int mi, output int se);
		if ($urandom_range(0, 99) < 20) begin
			hr = $urandom_range(0, 31);
			mi = $urandom_range(0, 63);
			se = $urandom_range(0, 63);
		end else begin
			hr = $urandom_range(0, 23);
			mi = $urandom_range(0, 59);
			se = $urandom_range(0, 59);
		end
	endtask

	task automatic test_random_scans(input int n_items);
		int hr, mi, se;
		int sent;
		sent = 0;
		while (sent < n_items) begin
			idling_on = !(sent >= n_items / 3 && sent < n_items / 2);
			if ($urandom_range(0, 99) < 75) begin
				random_time(hr, mi, se);
				send_scan(1'b1, hr, mi, se);
				random_time(hr, mi, se);
				send_scan(1'b0, hr, mi, se);
				sent += 2;
			end else begin
				random_time(hr, mi, se);
				send_scan($urandom_range(0, 1), hr, mi, se);
				sent++;
			end
		end
		idling_on = 1'b1;
		wait_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_digit_glyphs();
		test_level_without_edge();
		test_output_hold();
		test_random_scans(170);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d scans with %0d falling edges; %0d glyph segments checked,",
			scans_sent, falling_edges, segs_checked);
		$display("including random idling on both sides and a long output hold.");
		if (mismatch_count == 0 && glyph_segments.size() == 0)
			$display("tb_pov_clock_glyph_sequencer_core OK");
		else
			$display("tb_pov_clock_glyph_sequencer_core NOT OK");
		$finish;
	end

endmodule
